// ===== sv/dizt_pkg.sv =====
// ----------------------------------------------------------------------------
// dizt_pkg: shared definitions for the depth interpolate and z-test block
// Field widths, default screen sizes, request and axis codes, the minimum depth and the divider status.
// ----------------------------------------------------------------------------
package dizt_pkg;

	localparam int CUR_W        = 9;
	localparam int COORD_W      = 11;
	localparam int DEPTH_W      = 32;
	localparam int DEN_W        = 11;
	localparam int PROD_W       = DEPTH_W + DEN_W;
	localparam int SCREEN_W_DEF = 512;
	localparam int SCREEN_H_DEF = 512;

	localparam logic [DEPTH_W-1:0] DEPTH_MIN = {1'b1, {(DEPTH_W-1){1'b0}}};

	localparam logic REQ_TEST  = 1'b0;
	localparam logic REQ_CLEAR = 1'b1;

	localparam logic AXIS_X = 1'b0;
	localparam logic AXIS_Y = 1'b1;

	typedef struct packed {
		logic busy;
		logic done;
	} dizt_div_stat_t;

endpackage

// ===== sv/dizt_ram.sv =====
// ----------------------------------------------------------------------------
// dizt_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module dizt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== sv/dizt_div.sv =====
// ----------------------------------------------------------------------------
// dizt_div: restoring unsigned divider
// One quotient bit per cycle, dividend shifted in from the top.
// ----------------------------------------------------------------------------
module dizt_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [dizt_pkg::PROD_W-1:0]     dividend,
	input  logic [dizt_pkg::DEN_W-1:0]      divisor,
	output logic [dizt_pkg::DEPTH_W-1:0]    quotient,
	output dizt_pkg::dizt_div_stat_t        stat
);

	import dizt_pkg::*;

	localparam int CNT_W = $clog2(PROD_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PROD_W - 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [PROD_W-1:0] dq_q;
	logic [DEN_W-1:0] div_q;

	logic [DEN_W:0]   trial;
	logic             ge;
	logic [DEN_W-1:0] rem_n;

	always_comb begin
		trial = {rem_q, dq_q[PROD_W-1]};
		ge    = trial >= {1'b0, div_q};
		rem_n = ge ? DEN_W'(trial - {1'b0, div_q}) : trial[DEN_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == CNT_LAST);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dq_q  <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_n;
			dq_q  <= {dq_q[PROD_W-2:0], ge};
		end
	end

	assign quotient  = dq_q[DEPTH_W-1:0];
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// ===== sv/depth_interpolate_ztest.sv =====
// ----------------------------------------------------------------------------
// depth_interpolate_ztest: line depth interpolation with z-buffer test
// Interpolates Q16.16 depth at a cursor on a segment and updates the store.
// ----------------------------------------------------------------------------
// After reset the block sweeps the depth store, writing the minimum depth to
// one entry per cycle; in_ready stays low until all SCREEN_W * SCREEN_H
// entries (262144 at the defaults) are written. Items are then taken one at
// a time. A depth test that needs a real division runs S_PREP, S_MUL, S_DST,
// S_DIV on the bit-serial divider, S_FIN and S_WB; a clear request, a zero
// span or a ratio of one or more skips S_DST and S_DIV. The store entry is
// read on input transfer and, on a clear or pass, written back as the item
// ends, so consecutive items never overlap on the store. A finished result
// waits in the output register while the next item is being worked on.
// ----------------------------------------------------------------------------
module depth_interpolate_ztest #(
	parameter int SCREEN_W = dizt_pkg::SCREEN_W_DEF,
	parameter int SCREEN_H = dizt_pkg::SCREEN_H_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               req_type,
	input  logic [dizt_pkg::CUR_W-1:0]         cursor_x,
	input  logic [dizt_pkg::CUR_W-1:0]         cursor_y,
	input  logic                               axis,
	input  logic signed [dizt_pkg::COORD_W-1:0] start_x,
	input  logic signed [dizt_pkg::COORD_W-1:0] start_y,
	input  logic signed [dizt_pkg::COORD_W-1:0] end_x,
	input  logic signed [dizt_pkg::COORD_W-1:0] end_y,
	input  logic signed [dizt_pkg::DEPTH_W-1:0] start_depth,
	input  logic signed [dizt_pkg::DEPTH_W-1:0] end_depth,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               passed,
	output logic signed [dizt_pkg::DEPTH_W-1:0] pixel_depth
);

	import dizt_pkg::*;

	localparam int NPIX = SCREEN_W * SCREEN_H;
	localparam int AW   = $clog2(NPIX);
	localparam logic [AW-1:0] CLR_LAST = AW'(NPIX - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PREP,
		S_MUL,
		S_DST,
		S_DIV,
		S_FIN,
		S_WB
	} state_t;

	state_t state_q;

	logic          clr_active_q;
	logic [AW-1:0] clr_cnt_q;

	logic                       req_q;
	logic                       axis_q;
	logic [CUR_W-1:0]           cx_q;
	logic [CUR_W-1:0]           cy_q;
	logic signed [COORD_W-1:0]  sx_q;
	logic signed [COORD_W-1:0]  sy_q;
	logic signed [COORD_W-1:0]  ex_q;
	logic signed [COORD_W-1:0]  ey_q;
	logic signed [DEPTH_W-1:0]  sd_q;
	logic signed [DEPTH_W-1:0]  ed_q;
	logic                       onscr_q;
	logic [AW-1:0]              addr_q;

	logic signed [DEPTH_W-1:0]  stored_q;
	logic [DEN_W-1:0]           num_q;
	logic [DEN_W-1:0]           den_q;
	logic [DEPTH_W-1:0]         diff_mag_q;
	logic                       diff_neg_q;
	logic [PROD_W-1:0]          prod_q;
	logic signed [DEPTH_W-1:0]  depth_q;

	logic                       out_valid_q;
	logic                       passed_q;
	logic signed [DEPTH_W-1:0]  pixel_depth_q;

	logic                  accept;
	logic                  in_onscr;
	logic [AW-1:0]         in_addr;
	logic [CUR_W-1:0]      cur_a;
	logic signed [COORD_W-1:0] st_a;
	logic signed [COORD_W-1:0] en_a;
	logic signed [COORD_W:0]   num_s;
	logic signed [COORD_W:0]   den_s;
	logic signed [DEPTH_W:0]   diff_s;
	logic                  need_div;
	logic [DEPTH_W:0]      qs;
	logic [DEPTH_W:0]      sum;
	logic                  pass;
	logic                  out_free;

	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic [DEPTH_W-1:0]    ram_wdata;
	logic [DEPTH_W-1:0]    ram_rdata;

	logic                  div_start;
	logic [DEPTH_W-1:0]    div_quot;
	dizt_div_stat_t        div_stat;

	assign in_ready = (state_q == S_IDLE) && !clr_active_q;
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		in_onscr = (32'(cursor_x) < 32'(SCREEN_W)) && (32'(cursor_y) < 32'(SCREEN_H));
		in_addr  = AW'(32'(cursor_y) * 32'(SCREEN_W) + 32'(cursor_x));
	end

	always_comb begin
		cur_a  = (axis_q == AXIS_Y) ? cy_q : cx_q;
		st_a   = (axis_q == AXIS_Y) ? sy_q : sx_q;
		en_a   = (axis_q == AXIS_Y) ? ey_q : ex_q;
		num_s  = $signed({2'b00, cur_a}) - $signed({st_a[COORD_W-1], st_a});
		den_s  = $signed({en_a[COORD_W-1], en_a}) - $signed({st_a[COORD_W-1], st_a});
		diff_s = $signed({ed_q[DEPTH_W-1], ed_q}) - $signed({sd_q[DEPTH_W-1], sd_q});
	end

	assign need_div = (req_q == REQ_TEST) && (den_q != '0) && (num_q < den_q);

	always_comb begin
		qs   = diff_neg_q ? (DEPTH_W+1)'(-{1'b0, div_quot}) : {1'b0, div_quot};
		sum  = {sd_q[DEPTH_W-1], sd_q} + qs;
		pass = (req_q == REQ_TEST) && onscr_q && (depth_q > stored_q);
	end

	assign div_start = (state_q == S_DST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			clr_active_q <= 1'b1;
			clr_cnt_q    <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (clr_active_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == CLR_LAST) begin
					clr_active_q <= 1'b0;
				end
			end
			if ((state_q == S_WB) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					state_q <= S_MUL;
				end
				S_MUL: begin
					state_q <= need_div ? S_DST : S_FIN;
				end
				S_DST: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_stat.done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					state_q <= S_WB;
				end
				S_WB: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q   <= req_type;
			axis_q  <= axis;
			cx_q    <= cursor_x;
			cy_q    <= cursor_y;
			sx_q    <= start_x;
			sy_q    <= start_y;
			ex_q    <= end_x;
			ey_q    <= end_y;
			sd_q    <= start_depth;
			ed_q    <= end_depth;
			onscr_q <= in_onscr;
			addr_q  <= in_addr;
		end
		if (state_q == S_PREP) begin
			stored_q   <= ram_rdata;
			num_q      <= num_s[COORD_W] ? DEN_W'(-num_s) : num_s[DEN_W-1:0];
			den_q      <= den_s[COORD_W] ? DEN_W'(-den_s) : den_s[DEN_W-1:0];
			diff_neg_q <= diff_s[DEPTH_W];
			diff_mag_q <= diff_s[DEPTH_W] ? DEPTH_W'(-diff_s) : diff_s[DEPTH_W-1:0];
		end
		if (state_q == S_MUL) begin
			prod_q <= {{DEN_W{1'b0}}, diff_mag_q} * {{DEPTH_W{1'b0}}, num_q};
		end
		if (state_q == S_FIN) begin
			if (den_q == '0) begin
				depth_q <= sd_q;
			end else if (num_q >= den_q) begin
				depth_q <= ed_q;
			end else begin
				depth_q <= sum[DEPTH_W-1:0];
			end
		end
		if ((state_q == S_WB) && out_free) begin
			passed_q      <= pass;
			pixel_depth_q <= (req_q == REQ_CLEAR) ? '0 : depth_q;
		end
	end

	always_comb begin
		if (clr_active_q) begin
			ram_we    = 1'b1;
			ram_waddr = clr_cnt_q;
			ram_wdata = DEPTH_MIN;
		end else begin
			ram_we    = (state_q == S_WB) && out_free && onscr_q &&
			            ((req_q == REQ_CLEAR) || pass);
			ram_waddr = addr_q;
			ram_wdata = (req_q == REQ_CLEAR) ? DEPTH_MIN : depth_q;
		end
	end

	dizt_ram #(
		.WIDTH(DEPTH_W),
		.DEPTH(NPIX)
	) u_store (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_en   (accept),
		.rd_addr (in_addr),
		.rd_data (ram_rdata)
	);

	dizt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_q),
		.divisor  (den_q),
		.quotient (div_quot),
		.stat     (div_stat)
	);

	assign out_valid   = out_valid_q;
	assign passed      = passed_q;
	assign pixel_depth = pixel_depth_q;

	// no transfer in while the store is being cleared
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_active_q |-> !in_ready)
		else $error("input accepted during store clear");

	// divider is only started when idle
	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("divider started while busy");

	// waiting on the divider implies it is running or finishing
	a_div_running: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (div_stat.busy || div_stat.done))
		else $error("waiting on an idle divider");

	// a new result only follows write-back
	a_out_from_wb: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_WB))
		else $error("result raised outside write-back");

	// item write-back never overlaps the clear sweep
	a_wb_after_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !clr_active_q)
		else $error("item in flight during store clear");

endmodule
